[rtl/cstw_pkg.sv]
// Shared types, codes and helpers for the counting semaphore block.
// No dependencies; used by every module under rtl.
package cstw_pkg;

    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int DEF_THREAD_ID_BITS = 8;
    localparam int AMOUNT_W           = 16;
    localparam int COUNT_W            = 17;
    localparam int INIT_W             = 15;
    localparam int TIME_W             = 15;
    localparam int KIND_W             = 3;

    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_SIGNAL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] EV_GRANTED    = 3'd0;
    localparam logic [KIND_W-1:0] EV_BLOCKED    = 3'd1;
    localparam logic [KIND_W-1:0] EV_WOKE_SIG   = 3'd2;
    localparam logic [KIND_W-1:0] EV_WOKE_TIME  = 3'd3;
    localparam logic [KIND_W-1:0] EV_SIG_DONE   = 3'd4;
    localparam logic [KIND_W-1:0] EV_QUEUE_FULL = 3'd5;
    localparam logic [KIND_W-1:0] EV_TICK_DONE  = 3'd6;

    typedef enum logic [2:0] {
        CMD_WAIT,
        CMD_SIG_NEG,
        CMD_SIG_ONE,
        CMD_SIG_MULTI,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic [15:0]                  thread;
        logic signed [AMOUNT_W-1:0]   amount;
    } cmd_t;

    function automatic logic signed [COUNT_W-1:0] sat_count(
        input logic signed [COUNT_W:0] v
    );
        logic signed [COUNT_W:0] hi;
        logic signed [COUNT_W:0] lo;
        hi = (COUNT_W+1)'(65535);
        lo = -(COUNT_W+1)'(65536);
        if (v > hi) begin
            return hi[COUNT_W-1:0];
        end else if (v < lo) begin
            return lo[COUNT_W-1:0];
        end
        return v[COUNT_W-1:0];
    endfunction

endpackage

[rtl/cstw_front.sv]
// Front end: accepts input transactions, classifies them into commands.
// Depends on cstw_pkg.
module cstw_front import cstw_pkg::*; #(
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [THREAD_ID_BITS-1:0]  s_thread_id,
    input  logic signed [AMOUNT_W-1:0] s_amount,
    input  logic                       q_ready,
    output logic                       q_push,
    output cmd_t                       q_cmd
);

    assign s_ready = q_ready;
    // Drop the unused mode: it never reaches the queue.
    assign q_push  = s_valid && q_ready && (s_mode != MODE_UNUSED);

    always_comb begin
        q_cmd        = '0;
        q_cmd.thread = 16'(s_thread_id);
        q_cmd.amount = s_amount;
        unique case (s_mode)
            MODE_WAIT:   q_cmd.kind = CMD_WAIT;
            MODE_SIGNAL: begin
                if (s_amount < 0) begin
                    q_cmd.kind = CMD_SIG_NEG;
                end else if (s_amount <= 16'sd1) begin
                    q_cmd.kind = CMD_SIG_ONE;
                end else begin
                    q_cmd.kind = CMD_SIG_MULTI;
                end
            end
            MODE_TICK:   q_cmd.kind = CMD_TICK;
            default:     q_cmd.kind = CMD_TICK;
        endcase
    end

endmodule

[rtl/cstw_cmd_fifo.sv]
// Two-entry command queue between front end and back end.
// Depends on cstw_pkg.
module cstw_cmd_fifo import cstw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/cstw_back.sv]
// Back end: semaphore count, waiter queue cells and the result register.
// Depends on cstw_pkg.
module cstw_back import cstw_pkg::*; #(
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [INIT_W-1:0]          cfg_data,
    input  logic                       cmd_valid,
    input  cmd_t                       cmd,
    output logic                       cmd_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [KIND_W-1:0]          m_event_kind,
    output logic [THREAD_ID_BITS-1:0]  m_woken_thread,
    output logic signed [AMOUNT_W-1:0] m_result_value,
    output logic                       m_last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SIG_DONE = 4'b0010,
        ST_SIG_WALK = 4'b0100,
        ST_TICK     = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [COUNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]           total_reg, total_next;
    logic [CNT_W-1:0]           woke_reg, woke_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [TIME_W-1:0]          amt_reg, amt_next;

    logic [THREAD_ID_BITS-1:0]  thr_reg   [QUEUE_DEPTH];
    logic [TIME_W-1:0]          tim_reg   [QUEUE_DEPTH];
    logic                       timed_reg [QUEUE_DEPTH];
    logic [THREAD_ID_BITS-1:0]  thr_next  [QUEUE_DEPTH];
    logic [TIME_W-1:0]          tim_next  [QUEUE_DEPTH];
    logic                       timed_next[QUEUE_DEPTH];

    logic                       do_append, do_drop, do_rotate;
    logic                       emit, ev_last;
    logic [KIND_W-1:0]          ev_kind;
    logic [THREAD_ID_BITS-1:0]  ev_thr;
    logic signed [AMOUNT_W-1:0] ev_val;
    logic                       out_free;
    logic signed [COUNT_W-1:0]  count_inc;
    logic [TIME_W-1:0]          head_tim;

    assign out_free  = !m_valid || m_ready;
    assign count_inc = sat_count({count_reg[COUNT_W-1], count_reg} + 18'sd1);
    assign head_tim  = timed_reg[0] ? tim_reg[0] - TIME_W'(1) : tim_reg[0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        woke_next  = woke_reg;
        rem_next   = rem_reg;
        amt_next   = amt_reg;
        cmd_pop    = 1'b0;
        do_append  = 1'b0;
        do_drop    = 1'b0;
        do_rotate  = 1'b0;
        emit       = 1'b0;
        ev_kind    = EV_GRANTED;
        ev_thr     = '0;
        ev_val     = '0;
        ev_last    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_WAIT: begin
                            emit    = 1'b1;
                            ev_last = 1'b1;
                            ev_thr  = cmd.thread[THREAD_ID_BITS-1:0];
                            if (count_reg <= 0) begin
                                if (total_reg == CNT_W'(QUEUE_DEPTH)) begin
                                    ev_kind = EV_QUEUE_FULL;
                                end else begin
                                    do_append  = 1'b1;
                                    total_next = total_reg + CNT_W'(1);
                                    count_next = sat_count(
                                        {count_reg[COUNT_W-1], count_reg} - 18'sd1);
                                    ev_kind    = EV_BLOCKED;
                                end
                            end else begin
                                count_next = count_reg - 17'sd1;
                                ev_kind    = EV_GRANTED;
                            end
                        end
                        CMD_SIG_NEG: begin
                            emit    = 1'b1;
                            ev_last = 1'b1;
                            ev_kind = EV_SIG_DONE;
                            ev_val  = cmd.amount;
                        end
                        CMD_SIG_ONE: begin
                            count_next = count_inc;
                            emit       = 1'b1;
                            if (count_inc <= 0 && total_reg != '0) begin
                                ev_kind    = EV_WOKE_SIG;
                                ev_thr     = thr_reg[0];
                                do_drop    = 1'b1;
                                total_next = total_reg - CNT_W'(1);
                                state_next = ST_SIG_DONE;
                            end else begin
                                ev_kind = EV_SIG_DONE;
                                ev_val  = 16'sd1;
                                ev_last = 1'b1;
                            end
                        end
                        CMD_SIG_MULTI: begin
                            count_next = sat_count({count_reg[COUNT_W-1], count_reg}
                                                   + 18'(cmd.amount));
                            amt_next   = cmd.amount[TIME_W-1:0];
                            woke_next  = '0;
                            state_next = ST_SIG_WALK;
                        end
                        CMD_TICK: begin
                            rem_next   = total_reg;
                            state_next = ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SIG_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    ev_kind    = EV_SIG_DONE;
                    ev_val     = 16'sd1;
                    ev_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SIG_WALK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (TIME_W'(woke_reg) < amt_reg && total_reg != '0) begin
                        ev_kind    = EV_WOKE_SIG;
                        ev_thr     = thr_reg[0];
                        do_drop    = 1'b1;
                        total_next = total_reg - CNT_W'(1);
                        woke_next  = woke_reg + CNT_W'(1);
                    end else begin
                        ev_kind    = EV_SIG_DONE;
                        ev_val     = AMOUNT_W'(woke_reg);
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TICK: begin
                if (rem_reg == '0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        ev_kind    = EV_TICK_DONE;
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (timed_reg[0] && tim_reg[0] <= TIME_W'(1)) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        ev_kind    = EV_WOKE_TIME;
                        ev_thr     = thr_reg[0];
                        do_drop    = 1'b1;
                        total_next = total_reg - CNT_W'(1);
                        count_next = count_inc;
                        rem_next   = rem_reg - CNT_W'(1);
                    end
                end else begin
                    do_rotate = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we) begin
            count_next = COUNT_W'(cfg_data);
            total_next = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            thr_next[i]   = thr_reg[i];
            tim_next[i]   = tim_reg[i];
            timed_next[i] = timed_reg[i];
            if (do_drop || (do_rotate && CNT_W'(i) < total_reg - CNT_W'(1))) begin
                if (i < QUEUE_DEPTH - 1) begin
                    thr_next[i]   = thr_reg[(i + 1) % QUEUE_DEPTH];
                    tim_next[i]   = tim_reg[(i + 1) % QUEUE_DEPTH];
                    timed_next[i] = timed_reg[(i + 1) % QUEUE_DEPTH];
                end
            end else if (do_rotate && CNT_W'(i) == total_reg - CNT_W'(1)) begin
                thr_next[i]   = thr_reg[0];
                tim_next[i]   = head_tim;
                timed_next[i] = timed_reg[0];
            end
            if (do_append && CNT_W'(i) == total_reg) begin
                thr_next[i]   = cmd.thread[THREAD_ID_BITS-1:0];
                timed_next[i] = cmd.amount > 0;
                tim_next[i]   = (cmd.amount > 0) ? cmd.amount[TIME_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            thr_reg[i]   <= thr_next[i];
            tim_reg[i]   <= tim_next[i];
            timed_reg[i] <= timed_next[i];
        end
        woke_reg <= woke_next;
        rem_reg  <= rem_next;
        amt_reg  <= amt_next;
        if (emit) begin
            m_event_kind   <= ev_kind;
            m_woken_thread <= ev_thr;
            m_result_value <= ev_val;
            m_last         <= ev_last;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (emit) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/counting_semaphore_timed_waits.sv]
// Top level of the counting semaphore with timed waits.
// Depends on cstw_pkg, cstw_front, cstw_cmd_fifo and cstw_back.
//
// One counting semaphore with a FIFO of up to QUEUE_DEPTH waiting threads.
// A wait, signal or tick transaction enters the front end, which classifies
// it and drops mode 3; a two-entry command queue decouples it from the back
// end, which holds the count and the waiter cells and produces at most one
// result transaction per cycle into an output register, when that is free.
// A wait gives one result and a single signal one or two. A multi-signal
// first loads, then gives one result per woken waiter and a signal-done
// result; a tick first loads, then walks every queued waiter and ends with
// a tick-done result. The back end takes no new command until the current
// one is done. The walk rotates the waiter cells through the head, which is
// the only cell ever read. A cfg_we write of cfg_data loads the count and
// empties the queue; write it only while the block is idle.
module counting_semaphore_timed_waits import cstw_pkg::*; #(
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [INIT_W-1:0]          cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [THREAD_ID_BITS-1:0]  s_thread_id,
    input  logic signed [AMOUNT_W-1:0] s_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [KIND_W-1:0]          m_event_kind,
    output logic [THREAD_ID_BITS-1:0]  m_woken_thread,
    output logic signed [AMOUNT_W-1:0] m_result_value,
    output logic                       m_last
);

    logic q_ready, q_push, q_pop, q_valid;
    cmd_t q_cmd, q_head;

    // Classify and push commands.
    cstw_front #(.THREAD_ID_BITS(THREAD_ID_BITS)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_thread_id(s_thread_id),
        .s_amount   (s_amount),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // Hold commands while the back end walks the queue.
    cstw_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .push_ready(q_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_head)
    );

    // Execute commands and drive result transactions.
    cstw_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .cmd_valid     (q_valid),
        .cmd           (q_head),
        .cmd_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_woken_thread(m_woken_thread),
        .m_result_value(m_result_value),
        .m_last        (m_last)
    );

endmodule
